[rtl/core/pwsl_pkg.sv]
package pwsl_pkg;

  localparam int DEF_IMAGE_WIDTH  = 1024;
  localparam int DEF_IMAGE_HEIGHT = 1024;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 8;
  localparam int REG_IDX_W = 3;
  localparam int COEF_W    = 32;
  localparam int COORD_W   = 12;
  localparam int PIX_W     = 24;
  localparam int CORNER_W  = 17;
  localparam int FRAC_W    = 16;

  localparam int PROD_W = COEF_W + COORD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = SUM_W - 1;
  localparam int DQ_W   = MAG_W + FRAC_W;
  localparam int DIV_N  = DQ_W;

  localparam logic [REG_IDX_W-1:0] REG_COEF_X_FROM_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_X_FROM_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_X_OFFSET = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_Y_FROM_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_Y_FROM_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_Y_OFFSET = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PERSP_FROM_X  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_PERSP_FROM_Y  = 3'd7;

  localparam logic signed [COEF_W-1:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] kmag;
    logic [MAG_W-1:0] rem_x;
    logic [DQ_W-1:0]  dq_x;
    logic [MAG_W-1:0] rem_y;
    logic [DQ_W-1:0]  dq_y;
  } div_lane_t;

endpackage

[rtl/core/pwsl_if.sv]
interface pwsl_in_if import pwsl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  modport source (output valid, output out_col, output out_row, input ready);
  modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

interface pwsl_out_if import pwsl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [PIX_W-1:0]           pixel_index;
  logic signed [CORNER_W-1:0] corner_col;
  logic signed [CORNER_W-1:0] corner_row;
  logic                       valid_c0_r0;
  logic                       valid_c0_r1;
  logic                       valid_c1_r0;
  logic                       valid_c1_r1;
  logic [FRAC_W-1:0]          frac_col;
  logic [FRAC_W-1:0]          frac_row;
  modport source (output valid, output pixel_index, output corner_col, output corner_row,
                  output valid_c0_r0, output valid_c0_r1, output valid_c1_r0,
                  output valid_c1_r1, output frac_col, output frac_row, input ready);
  modport sink   (input valid, input pixel_index, input corner_col, input corner_row,
                  input valid_c0_r0, input valid_c0_r1, input valid_c1_r0,
                  input valid_c1_r1, input frac_col, input frac_row, output ready);
endinterface

interface pwsl_cfg_if import pwsl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/projective_warp_sample_locator_core.sv]
// channel  | modport | payload
// in_i     | sink    | out_col, out_row
// out_o    | source  | pixel_index, corners, neighbor flags, fractions
// cfg_i    | sink    | index, data (always ready)
//
// one transaction per cycle sustained while the output is not stalled;
// the two radix-2 dividers are pipelined, one quotient bit per stage
// rst_ni clears valid bits and loads coefficient reset values
// a stalled output freezes the whole pipeline; nothing is lost or repeated
module projective_warp_sample_locator_core import pwsl_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pwsl_in_if.sink    in_i,
  pwsl_out_if.source out_o,
  pwsl_cfg_if.sink   cfg_i
);

  localparam logic [PIX_W+1:0] IW_EXT = (PIX_W+2)'(IMAGE_WIDTH);
  localparam logic signed [SUM_W:0] W_S  = (SUM_W+1)'(IMAGE_WIDTH);
  localparam logic signed [SUM_W:0] H_S  = (SUM_W+1)'(IMAGE_HEIGHT);
  localparam logic signed [SUM_W:0] W1_S = (SUM_W+1)'(IMAGE_WIDTH - 1);
  localparam logic signed [SUM_W:0] H1_S = (SUM_W+1)'(IMAGE_HEIGHT - 1);
  localparam logic signed [SUM_W:0] M1_S = -(SUM_W+1)'(1);
  localparam logic signed [SUM_W:0] CMAX = (SUM_W+1)'(65535);
  localparam logic signed [SUM_W:0] CMIN = -(SUM_W+1)'(65536);

  logic signed [COEF_W-1:0] coef_q [NUM_REGS];
  logic                     adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) coef_q[i] <= '0;
      coef_q[REG_COEF_X_FROM_X] <= ONE_Q16;
      coef_q[REG_COEF_Y_FROM_Y] <= ONE_Q16;
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(NUM_REGS))) begin
      coef_q[cfg_i.index[REG_IDX_W-1:0]] <= cfg_i.data;
    end
  end

  // stage 0: capture and range check
  logic               s0_v_q;
  logic [COORD_W-1:0] s0_x_q, s0_y_q;

  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_i.valid && ((COORD_W+1)'(in_i.out_col) < (COORD_W+1)'(IMAGE_WIDTH))
                && ((COORD_W+1)'(in_i.out_row) < (COORD_W+1)'(IMAGE_HEIGHT));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_x_q <= in_i.out_col;
      s0_y_q <= in_i.out_row;
    end
  end

  // stage 1: products
  logic                      s1_v_q;
  logic signed [PROD_W-1:0]  s1_p_q [6];
  logic [PIX_W-1:0]          s1_pix_q;
  logic signed [COORD_W:0]   xs, ys;
  logic [PIX_W+1:0]          pix_w;

  assign xs    = $signed({1'b0, s0_x_q});
  assign ys    = $signed({1'b0, s0_y_q});
  assign pix_w = (PIX_W+2)'(s0_y_q) * IW_EXT + (PIX_W+2)'(s0_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (adv) s1_v_q <= s0_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_p_q[0] <= PROD_W'(coef_q[REG_COEF_X_FROM_X]) * PROD_W'(xs);
      s1_p_q[1] <= PROD_W'(coef_q[REG_COEF_X_FROM_Y]) * PROD_W'(ys);
      s1_p_q[2] <= PROD_W'(coef_q[REG_COEF_Y_FROM_X]) * PROD_W'(xs);
      s1_p_q[3] <= PROD_W'(coef_q[REG_COEF_Y_FROM_Y]) * PROD_W'(ys);
      s1_p_q[4] <= PROD_W'(coef_q[REG_PERSP_FROM_X]) * PROD_W'(xs);
      s1_p_q[5] <= PROD_W'(coef_q[REG_PERSP_FROM_Y]) * PROD_W'(ys);
      s1_pix_q  <= pix_w[PIX_W-1:0];
    end
  end

  // stage 2: sums
  logic                    s2_v_q;
  logic signed [SUM_W-1:0] s2_nx_q, s2_ny_q, s2_k_q;
  logic [PIX_W-1:0]        s2_pix_q;
  logic signed [SUM_W-1:0] k_d;

  assign k_d = SUM_W'(s1_p_q[4]) + SUM_W'(s1_p_q[5]) + SUM_W'(ONE_Q16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (adv) s2_v_q <= s1_v_q && (k_d != '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_k_q   <= k_d;
      s2_nx_q  <= SUM_W'(s1_p_q[0]) + SUM_W'(s1_p_q[1]) + SUM_W'(coef_q[REG_COEF_X_OFFSET]);
      s2_ny_q  <= SUM_W'(s1_p_q[2]) + SUM_W'(s1_p_q[3]) + SUM_W'(coef_q[REG_COEF_Y_OFFSET]);
      s2_pix_q <= s1_pix_q;
    end
  end

  // stage 3: signs and magnitudes
  logic                    s3_v_q;
  div_lane_t               s3_q;
  logic signed [SUM_W-1:0] ax, ay, ak;

  assign ax = s2_nx_q[SUM_W-1] ? -s2_nx_q : s2_nx_q;
  assign ay = s2_ny_q[SUM_W-1] ? -s2_ny_q : s2_ny_q;
  assign ak = s2_k_q[SUM_W-1]  ? -s2_k_q  : s2_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (adv) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q.pix   <= s2_pix_q;
      s3_q.neg_x <= s2_nx_q[SUM_W-1] ^ s2_k_q[SUM_W-1];
      s3_q.neg_y <= s2_ny_q[SUM_W-1] ^ s2_k_q[SUM_W-1];
      s3_q.kmag  <= ak[MAG_W-1:0];
      s3_q.rem_x <= '0;
      s3_q.rem_y <= '0;
      s3_q.dq_x  <= {ax[MAG_W-1:0], {FRAC_W{1'b0}}};
      s3_q.dq_y  <= {ay[MAG_W-1:0], {FRAC_W{1'b0}}};
    end
  end

  // divider pipeline, one quotient bit per stage
  function automatic logic [MAG_W+DQ_W-1:0] div_step(logic [MAG_W-1:0] rem,
                                                     logic [DQ_W-1:0] dq,
                                                     logic [MAG_W-1:0] d);
    logic [MAG_W:0] t;
    logic [MAG_W:0] s;
    t = {rem, dq[DQ_W-1]};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) return {s[MAG_W-1:0], dq[DQ_W-2:0], 1'b1};
    else return {t[MAG_W-1:0], dq[DQ_W-2:0], 1'b0};
  endfunction

  logic [DIV_N-1:0] dv_q;
  div_lane_t        dl_q [DIV_N];

  for (genvar g = 0; g < DIV_N; g++) begin : g_div
    div_lane_t src;
    logic      src_v;
    if (g == 0) begin : g_first
      assign src   = s3_q;
      assign src_v = s3_v_q;
    end else begin : g_next
      assign src   = dl_q[g-1];
      assign src_v = dv_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[g] <= 1'b0;
      else if (adv) dv_q[g] <= src_v;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dl_q[g].pix   <= src.pix;
        dl_q[g].neg_x <= src.neg_x;
        dl_q[g].neg_y <= src.neg_y;
        dl_q[g].kmag  <= src.kmag;
        {dl_q[g].rem_x, dl_q[g].dq_x} <= div_step(src.rem_x, src.dq_x, src.kmag);
        {dl_q[g].rem_y, dl_q[g].dq_y} <= div_step(src.rem_y, src.dq_y, src.kmag);
      end
    end
  end

  // floor correction
  logic                   fa_v_q;
  logic [PIX_W-1:0]       fa_pix_q;
  logic signed [DQ_W:0]   fa_qx_q, fa_qy_q;
  div_lane_t              dl_last;
  logic signed [DQ_W:0]   qmx, qmy;

  assign dl_last = dl_q[DIV_N-1];
  assign qmx = $signed({1'b0, dl_last.dq_x});
  assign qmy = $signed({1'b0, dl_last.dq_y});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fa_v_q <= 1'b0;
    else if (adv) fa_v_q <= dv_q[DIV_N-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_pix_q <= dl_last.pix;
      if (!dl_last.neg_x) fa_qx_q <= qmx;
      else if (dl_last.rem_x != '0) fa_qx_q <= ~qmx;
      else fa_qx_q <= -qmx;
      if (!dl_last.neg_y) fa_qy_q <= qmy;
      else if (dl_last.rem_y != '0) fa_qy_q <= ~qmy;
      else fa_qy_q <= -qmy;
    end
  end

  // neighbor test, saturation, output register
  logic signed [SUM_W:0] x0, y0;
  logic                  v00, v01, v10, v11;
  logic                  cx0, cx1, cy0, cy1;
  logic                  out_valid_q;

  assign x0  = (SUM_W+1)'(fa_qx_q >>> FRAC_W);
  assign y0  = (SUM_W+1)'(fa_qy_q >>> FRAC_W);
  assign cx0 = (x0 >= 0) && (x0 < W_S);
  assign cx1 = (x0 >= M1_S) && (x0 < W1_S);
  assign cy0 = (y0 >= 0) && (y0 < H_S);
  assign cy1 = (y0 >= M1_S) && (y0 < H1_S);
  assign v00 = cx0 && cy0;
  assign v01 = cx0 && cy1;
  assign v10 = cx1 && cy0;
  assign v11 = cx1 && cy1;

  assign adv = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= fa_v_q && (v00 || v01 || v10 || v11);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_o.pixel_index <= fa_pix_q;
      out_o.corner_col  <= (x0 > CMAX) ? CMAX[CORNER_W-1:0] :
                           (x0 < CMIN) ? CMIN[CORNER_W-1:0] : x0[CORNER_W-1:0];
      out_o.corner_row  <= (y0 > CMAX) ? CMAX[CORNER_W-1:0] :
                           (y0 < CMIN) ? CMIN[CORNER_W-1:0] : y0[CORNER_W-1:0];
      out_o.valid_c0_r0 <= v00;
      out_o.valid_c0_r1 <= v01;
      out_o.valid_c1_r0 <= v10;
      out_o.valid_c1_r1 <= v11;
      out_o.frac_col    <= fa_qx_q[FRAC_W-1:0];
      out_o.frac_row    <= fa_qy_q[FRAC_W-1:0];
    end
  end

  assign out_o.valid = out_valid_q;

  a_any_neighbor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.valid_c0_r0 || out_o.valid_c0_r1 ||
                     out_o.valid_c1_r0 || out_o.valid_c1_r1))
    else $error("result with no neighbor inside");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output");

  a_corner_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.valid_c0_r0) |-> (out_o.corner_col >= 0 && out_o.corner_row >= 0))
    else $error("corner flag inconsistent with corner");

endmodule
